[src/swk_pkg.sv]
// ---------------------------------------------------------------------------
// swk_pkg: shared types and constants for swerve wheel kinematics
// Payload structs, register indexes, CORDIC arctangent table and helpers.
// ---------------------------------------------------------------------------
package swk_pkg;

	localparam int VEL_W        = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int LOOP_STAGES  = 8;
	localparam int SQ_PER_STAGE = 2;
	localparam int CO_PER_STAGE = CORDIC_STEPS / LOOP_STAGES;
	localparam int NUM_WHEELS   = 4;

	localparam logic signed [15:0] ANGLE_HALF_TURN = 16'sd23040;

	// register indexes
	localparam logic [7:0] REG_HALF_WHEELBASE = 8'd0;
	localparam logic [7:0] REG_HALF_TRACK     = 8'd1;

	localparam logic [15:0] HALF_WHEELBASE_RST = 16'd1024;
	localparam logic [15:0] HALF_TRACK_RST     = 16'd614;

	typedef struct packed {
		logic signed [15:0] forward_speed;
		logic signed [15:0] lateral_speed;
		logic signed [15:0] yaw_rate;
	} cmd_t;

	typedef struct packed {
		logic        [15:0] front_left_speed;
		logic signed [15:0] front_left_angle;
		logic        [15:0] front_right_speed;
		logic signed [15:0] front_right_angle;
		logic        [15:0] rear_left_speed;
		logic signed [15:0] rear_left_angle;
		logic        [15:0] rear_right_speed;
		logic signed [15:0] rear_right_angle;
	} wheels_t;

	// per-wheel state through the sqrt / CORDIC stages
	typedef struct packed {
		logic        [33:0] rem;
		logic        [33:0] res;
		logic signed [35:0] x;
		logic signed [35:0] y;
		logic signed [31:0] z;
		logic signed [15:0] base;
		logic               zero;
	} wstate_t;

	// arctangent of 2^-i in 2^-23 degree
	function automatic logic signed [31:0] atan_lut(input logic [4:0] i);
		logic signed [31:0] r;
		unique case (i)
			5'd0:  r = 32'sd377487360;
			5'd1:  r = 32'sd222843801;
			5'd2:  r = 32'sd117744544;
			5'd3:  r = 32'sd59768969;
			5'd4:  r = 32'sd30000467;
			5'd5:  r = 32'sd15014858;
			5'd6:  r = 32'sd7509261;
			5'd7:  r = 32'sd3754860;
			5'd8:  r = 32'sd1877459;
			5'd9:  r = 32'sd938733;
			5'd10: r = 32'sd469367;
			5'd11: r = 32'sd234684;
			5'd12: r = 32'sd117342;
			5'd13: r = 32'sd58671;
			5'd14: r = 32'sd29335;
			5'd15: r = 32'sd14668;
			5'd16: r = 32'sd7334;
			5'd17: r = 32'sd3667;
			5'd18: r = 32'sd1833;
			5'd19: r = 32'sd917;
			5'd20: r = 32'sd458;
			5'd21: r = 32'sd229;
			5'd22: r = 32'sd115;
			5'd23: r = 32'sd57;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// saturate a component sum to the velocity width
	function automatic logic signed [15:0] sat_vel(input logic signed [21:0] v);
		logic signed [15:0] r;
		if (v > 22'sd32767)
			r = 16'sh7fff;
		else if (v < -22'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	// one restoring square-root digit, bit weight 4^k
	function automatic wstate_t sqrt_step(input wstate_t s, input logic [3:0] k);
		wstate_t     r;
		logic [33:0] bitw;
		logic [33:0] t;
		r    = s;
		bitw = 34'd1 << {k, 1'b0};
		t    = s.res + bitw;
		if (s.rem >= t) begin
			r.rem = s.rem - t;
			r.res = (s.res >> 1) + bitw;
		end else begin
			r.res = s.res >> 1;
		end
		return r;
	endfunction

	// one CORDIC vectoring rotation
	function automatic wstate_t cordic_step(input wstate_t s, input logic [4:0] i);
		wstate_t            r;
		logic signed [35:0] dx;
		logic signed [35:0] dy;
		r  = s;
		dx = s.y >>> i;
		dy = s.x >>> i;
		if (s.y >= 0) begin
			r.x = s.x + dx;
			r.y = s.y - dy;
			r.z = s.z + atan_lut(i);
		end else begin
			r.x = s.x - dx;
			r.y = s.y + dy;
			r.z = s.z - atan_lut(i);
		end
		return r;
	endfunction

endpackage

[src/swerve_wheel_kinematics.sv]
// Pipeline: 13 register stages (4 front stages, 8 sqrt/CORDIC stages, 1 output register).
// Throughput: one command per cycle while no result waits on out_ready. The 8 loop
// stages (2 sqrt digits, 3 CORDIC rotations each) make up most of the pipe.
// The whole pipe holds while a result waits on out_ready.
// Reset: all valid bits clear, half_wheelbase = 1024, half_track = 614.
// ---------------------------------------------------------------------------
// swerve_wheel_kinematics: four-wheel swerve inverse kinematics
// Body velocity command in, speed and steering angle of four wheels out.
// ---------------------------------------------------------------------------
module swerve_wheel_kinematics (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  swk_pkg::cmd_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output swk_pkg::wheels_t out_data,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [7:0]     cfg_index,
	input  logic [15:0]    cfg_data
);
	import swk_pkg::*;

	logic [15:0] half_wheelbase_q;
	logic [15:0] half_track_q;
	logic        en;

	// stage 1: lever products
	logic               v_s1;
	logic signed [32:0] ptw_s1, ptl_s1;
	cmd_t               cmd_s1;

	// stage 2: rounded levers and saturated components
	logic               v_s2;
	logic signed [15:0] x_s2 [NUM_WHEELS];
	logic signed [15:0] y_s2 [NUM_WHEELS];
	logic signed [20:0] tw, tl;

	// stage 3: squares
	logic               v_s3;
	logic signed [15:0] x_s3 [NUM_WHEELS];
	logic signed [15:0] y_s3 [NUM_WHEELS];
	logic [31:0]        sqx_s3 [NUM_WHEELS];
	logic [31:0]        sqy_s3 [NUM_WHEELS];

	// loop stages; index 0 is stage 4
	logic [LOOP_STAGES:0] v_lp;
	wstate_t              lp_s [LOOP_STAGES+1][NUM_WHEELS];

	logic    out_valid_q;
	wheels_t out_q;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_wheelbase_q <= HALF_WHEELBASE_RST;
			half_track_q     <= HALF_TRACK_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_HALF_WHEELBASE)
				half_wheelbase_q <= cfg_data;
			else if (cfg_index == REG_HALF_TRACK)
				half_track_q <= cfg_data;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_lp        <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_lp        <= {v_lp[LOOP_STAGES-1:0], v_s3};
			out_valid_q <= v_lp[LOOP_STAGES];
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= in_data;
			ptw_s1 <= in_data.yaw_rate * $signed({1'b0, half_track_q});
			ptl_s1 <= in_data.yaw_rate * $signed({1'b0, half_wheelbase_q});
		end
	end

	// stage 2
	always_comb begin
		tw = 21'((ptw_s1 + 33'sd2048) >>> 12);
		tl = 21'((ptl_s1 + 33'sd2048) >>> 12);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2[0] <= sat_vel(22'(cmd_s1.forward_speed) - 22'(tw));
			y_s2[0] <= sat_vel(22'(cmd_s1.lateral_speed) + 22'(tl));
			x_s2[1] <= sat_vel(22'(cmd_s1.forward_speed) + 22'(tw));
			y_s2[1] <= sat_vel(22'(cmd_s1.lateral_speed) + 22'(tl));
			x_s2[2] <= sat_vel(22'(cmd_s1.forward_speed) - 22'(tw));
			y_s2[2] <= sat_vel(22'(cmd_s1.lateral_speed) - 22'(tl));
			x_s2[3] <= sat_vel(22'(cmd_s1.forward_speed) + 22'(tw));
			y_s2[3] <= sat_vel(22'(cmd_s1.lateral_speed) - 22'(tl));
		end
	end

	// stage 3 and stage 4 per wheel
	for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_wheel
		logic [15:0] ax, ay;
		logic signed [35:0] xm, ym;

		assign ax = x_s2[w][15] ? 16'(-17'(x_s2[w])) : 16'(x_s2[w]);
		assign ay = y_s2[w][15] ? 16'(-17'(y_s2[w])) : 16'(y_s2[w]);

		always_ff @(posedge clk) begin
			if (en) begin
				x_s3[w]   <= x_s2[w];
				y_s3[w]   <= y_s2[w];
				sqx_s3[w] <= {16'd0, ax} * {16'd0, ax};
				sqy_s3[w] <= {16'd0, ay} * {16'd0, ay};
			end
		end

		// mirror left half-plane through the origin
		assign xm = x_s3[w][15] ? -36'(x_s3[w]) : 36'(x_s3[w]);
		assign ym = x_s3[w][15] ? -36'(y_s3[w]) : 36'(y_s3[w]);

		always_ff @(posedge clk) begin
			if (en) begin
				lp_s[0][w].rem  <= 34'(sqx_s3[w]) + 34'(sqy_s3[w]);
				lp_s[0][w].res  <= '0;
				lp_s[0][w].x    <= xm <<< 16;
				lp_s[0][w].y    <= ym <<< 16;
				lp_s[0][w].z    <= '0;
				lp_s[0][w].zero <= (x_s3[w] == 16'sd0) && (y_s3[w] == 16'sd0);
				if (!x_s3[w][15])
					lp_s[0][w].base <= 16'sd0;
				else if (!y_s3[w][15])
					lp_s[0][w].base <= ANGLE_HALF_TURN;
				else
					lp_s[0][w].base <= -ANGLE_HALF_TURN;
			end
		end
	end

	// loop stages: two sqrt digits and three CORDIC rotations each
	for (genvar j = 0; j < LOOP_STAGES; j++) begin : g_loop
		for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_w
			wstate_t nxt;
			always_comb begin
				nxt = lp_s[j][w];
				for (int t = 0; t < SQ_PER_STAGE; t++)
					nxt = sqrt_step(nxt, 4'(15 - SQ_PER_STAGE * j - t));
				for (int t = 0; t < CO_PER_STAGE; t++)
					nxt = cordic_step(nxt, 5'(CO_PER_STAGE * j + t));
			end
			always_ff @(posedge clk) begin
				if (en)
					lp_s[j+1][w] <= nxt;
			end
		end
	end

	// output: speed rounding, angle rounding and clamp
	logic [15:0]        spd [NUM_WHEELS];
	logic signed [15:0] ang [NUM_WHEELS];

	for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_out
		logic signed [18:0] r;
		always_comb begin
			spd[w] = lp_s[LOOP_STAGES][w].res[15:0]
				+ 16'(lp_s[LOOP_STAGES][w].rem > lp_s[LOOP_STAGES][w].res);
			r = 19'((34'(lp_s[LOOP_STAGES][w].z) + 34'sd32768) >>> 16)
				+ 19'(lp_s[LOOP_STAGES][w].base);
			if (lp_s[LOOP_STAGES][w].zero)
				ang[w] = 16'sd0;
			else if (r > 19'(ANGLE_HALF_TURN))
				ang[w] = ANGLE_HALF_TURN;
			else if (r < -19'(ANGLE_HALF_TURN))
				ang[w] = -ANGLE_HALF_TURN;
			else
				ang[w] = r[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.front_left_speed  <= spd[0];
			out_q.front_left_angle  <= ang[0];
			out_q.front_right_speed <= spd[1];
			out_q.front_right_angle <= ang[1];
			out_q.rear_left_speed   <= spd[2];
			out_q.rear_left_angle   <= ang[2];
			out_q.rear_right_speed  <= spd[3];
			out_q.rear_right_angle  <= ang[3];
		end
	end

	// an accepted command enters stage 1
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted command did not enter the pipe");

	// a zero speed only comes from a zero vector, whose angle is zero
	a_zero_fl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.front_left_speed == 16'd0 |-> out_data.front_left_angle == 16'sd0)
		else $error("front left zero speed with nonzero angle");

	// angles stay within a half turn (checked on the rear right wheel)
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.rear_right_angle <= ANGLE_HALF_TURN
			&& out_data.rear_right_angle >= -ANGLE_HALF_TURN)
		else $error("rear right angle out of range");

endmodule

[tb/tb_swerve_wheel_kinematics.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_swerve_wheel_kinematics: self-checking bench for swerve wheel kinematics
// Drives body velocity commands through valid/ready, predicts wheel speeds and
// steering angles in a bit-exact model or takes typed-in results for directed rows, and compares each result.
// ---------------------------------------------------------------------------
module tb_swerve_wheel_kinematics;
	import swk_pkg::*;

	localparam int LATENCY   = 13;
	localparam int IDLE_MAX  = 11;
	localparam int N_RANDOM  = 750;
	localparam int WDOG_MAX  = 5000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	cmd_t             in_data;
	logic             out_valid;
	logic             out_ready;
	wheels_t          out_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [7:0]       cfg_index;
	logic [15:0]      cfg_data;

	// predictor copy of the registers
	logic [15:0]      pred_wheelbase;
	logic [15:0]      pred_track;

	wheels_t          wheel_queue[$];
	int               err_count;
	int               cmd_sent;
	int               res_seen;
	int               idle_cycles;
	bit               hold_off;

	// directed rows: command plus an optional typed-in result
	typedef struct {
		cmd_t    cmd;
		bit      has_exp;
		wheels_t exp;
	} row_t;

	swerve_wheel_kinematics u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// floor shift of a signed value
	function automatic longint fshift(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_vel(input longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint round_sqrt(input longint unsigned n);
		longint unsigned acc, bitw, rem;
		acc  = 0;
		bitw = 64'd1 << 62;
		rem  = n;
		while (bitw > rem) bitw >>= 2;
		while (bitw != 0) begin
			if (rem >= acc + bitw) begin
				rem -= acc + bitw;
				acc = (acc >> 1) + bitw;
			end else begin
				acc >>= 1;
			end
			bitw >>= 2;
		end
		if (n - acc * acc > acc) acc++;
		if (acc > 65535) acc = 65535;
		return acc;
	endfunction

	function automatic longint steer_angle(input longint x0, input longint y0);
		longint x, y, z, dx, dy, base, r;
		longint tab[24] = '{377487360, 222843801, 117744544, 59768969, 30000467,
			15014858, 7509261, 3754860, 1877459, 938733, 469367, 234684, 117342,
			58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57};
		x = x0;
		y = y0;
		z = 0;
		base = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			base = (y >= 0) ? 23040 : -23040;
			x = -x;
			y = -y;
		end
		x *= 65536;
		y *= 65536;
		for (int i = 0; i < 24; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (y >= 0) begin
				x += dx; y -= dy; z += tab[i];
			end else begin
				x -= dx; y += dy; z -= tab[i];
			end
		end
		r = base + fshift(z + 32768, 16);
		if (r > 23040) r = 23040;
		if (r < -23040) r = -23040;
		return r;
	endfunction

	// wheel speeds and angles for one body command
	function automatic wheels_t wheel_targets(input cmd_t c);
		wheels_t w;
		longint fwd, lat, tw, tl, xs[4], ys[4], sp[4], an[4];
		fwd = c.forward_speed;
		lat = c.lateral_speed;
		tw  = fshift(longint'(c.yaw_rate) * longint'(pred_track) + 2048, 12);
		tl  = fshift(longint'(c.yaw_rate) * longint'(pred_wheelbase) + 2048, 12);
		xs[0] = clamp_vel(fwd - tw); ys[0] = clamp_vel(lat + tl);
		xs[1] = clamp_vel(fwd + tw); ys[1] = clamp_vel(lat + tl);
		xs[2] = clamp_vel(fwd - tw); ys[2] = clamp_vel(lat - tl);
		xs[3] = clamp_vel(fwd + tw); ys[3] = clamp_vel(lat - tl);
		for (int k = 0; k < 4; k++) begin
			sp[k] = round_sqrt(xs[k] * xs[k] + ys[k] * ys[k]);
			an[k] = steer_angle(xs[k], ys[k]);
		end
		w.front_left_speed  = sp[0][15:0];
		w.front_left_angle  = an[0][15:0];
		w.front_right_speed = sp[1][15:0];
		w.front_right_angle = an[1][15:0];
		w.rear_left_speed   = sp[2][15:0];
		w.rear_left_angle   = an[2][15:0];
		w.rear_right_speed  = sp[3][15:0];
		w.rear_right_angle  = an[3][15:0];
		return w;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		err_count++;
		$display("MISMATCH result %0d %s: got %0d expected %0d", res_seen, what, got, want);
	endtask

	// wait for quiet pipe, then write one register
	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		while (wheel_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_HALF_WHEELBASE) pred_wheelbase = val;
		else if (idx == REG_HALF_TRACK) pred_track = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// one command transfer, with a random gap in front
	task automatic send_cmd(input cmd_t c, input bit has_exp, input wheels_t exp);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		wheel_queue.push_back(has_exp ? exp : wheel_targets(c));
		cmd_sent++;
	endtask

	function automatic cmd_t rand_cmd(input int mode);
		cmd_t c;
		c.forward_speed = 16'($urandom);
		c.lateral_speed = 16'($urandom);
		c.yaw_rate      = 16'($urandom);
		// mostly realistic speeds, some full range
		if (mode < 6) begin
			c.forward_speed = 16'(int'($urandom_range(0, 2047)) - 1024);
			c.lateral_speed = 16'(int'($urandom_range(0, 2047)) - 1024);
			c.yaw_rate      = 16'(int'($urandom_range(0, 2047)) - 1024);
		end else if (mode == 6) begin
			c.yaw_rate = '0;
		end else if (mode == 7) begin
			c.forward_speed = '0;
			c.lateral_speed = '0;
		end
		return c;
	endfunction

	// result checking
	always @(posedge clk) begin
		wheels_t want;
		if (arst_n && out_valid && out_ready) begin
			if (wheel_queue.size() == 0) begin
				err_count++;
				$display("MISMATCH unexpected result %0d", res_seen);
			end else begin
				want = wheel_queue.pop_front();
				if (out_data.front_left_speed !== want.front_left_speed)
					report_mismatch("front_left_speed", out_data.front_left_speed,
						want.front_left_speed);
				if (out_data.front_left_angle !== want.front_left_angle)
					report_mismatch("front_left_angle", out_data.front_left_angle,
						want.front_left_angle);
				if (out_data.front_right_speed !== want.front_right_speed)
					report_mismatch("front_right_speed", out_data.front_right_speed,
						want.front_right_speed);
				if (out_data.front_right_angle !== want.front_right_angle)
					report_mismatch("front_right_angle", out_data.front_right_angle,
						want.front_right_angle);
				if (out_data.rear_left_speed !== want.rear_left_speed)
					report_mismatch("rear_left_speed", out_data.rear_left_speed,
						want.rear_left_speed);
				if (out_data.rear_left_angle !== want.rear_left_angle)
					report_mismatch("rear_left_angle", out_data.rear_left_angle,
						want.rear_left_angle);
				if (out_data.rear_right_speed !== want.rear_right_speed)
					report_mismatch("rear_right_speed", out_data.rear_right_speed,
						want.rear_right_speed);
				if (out_data.rear_right_angle !== want.rear_right_angle)
					report_mismatch("rear_right_angle", out_data.rear_right_angle,
						want.rear_right_angle);
			end
			res_seen++;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int wait_n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (60) @(negedge clk);
				hold_off = 1'b0;
			end
			wait_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
			if ((cmd_sent / 100) % 2 == 1) wait_n = 0;
			out_ready <= (wait_n == 0);
			if (wait_n != 0) begin
				repeat (wait_n) @(negedge clk);
				out_ready <= 1'b1;
			end
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("Watchdog expired with %0d results pending", wheel_queue.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	// stimulus
	initial begin
		row_t    rows[$];
		row_t    r;
		wheels_t zero_w;
		cmd_t    c;
		logic [15:0] wb_set[4];
		logic [15:0] tr_set[4];

		wb_set      = '{16'd0, 16'hffff, 16'd2048, 16'd300};
		tr_set      = '{16'hffff, 16'd0, 16'd1500, 16'd4096};
		err_count   = 0;
		cmd_sent    = 0;
		res_seen    = 0;
		idle_cycles = 0;
		hold_off    = 0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_data     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		pred_wheelbase = HALF_WHEELBASE_RST;
		pred_track     = HALF_TRACK_RST;
		zero_w = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table: zero vector, axes, extremes, saturation
		r.has_exp = 1; r.exp = zero_w;
		r.cmd = '{16'sd0, 16'sd0, 16'sd0}; rows.push_back(r);
		// negative x axis: half turn
		r.exp = '{16'd256, 16'sd23040, 16'd256, 16'sd23040,
			16'd256, 16'sd23040, 16'd256, 16'sd23040};
		r.cmd = '{-16'sd256, 16'sd0, 16'sd0}; rows.push_back(r);
		r.exp = '{16'd256, 16'sd0, 16'd256, 16'sd0, 16'd256, 16'sd0, 16'd256, 16'sd0};
		r.cmd = '{16'sd256, 16'sd0, 16'sd0}; rows.push_back(r);
		r.exp = '{16'd256, 16'sd11520, 16'd256, 16'sd11520,
			16'd256, 16'sd11520, 16'd256, 16'sd11520};
		r.cmd = '{16'sd0, 16'sd256, 16'sd0}; rows.push_back(r);
		// full negative forward speed on the negative x axis: half turn
		r.exp = '{16'd32768, 16'sd23040, 16'd32768, 16'sd23040,
			16'd32768, 16'sd23040, 16'd32768, 16'sd23040};
		r.cmd = '{-16'sd32768, 16'sd0, 16'sd0}; rows.push_back(r);
		r.has_exp = 0;
		r.cmd = '{-16'sd32768, -16'sd32768, 16'sd0}; rows.push_back(r);
		r.cmd = '{16'sd32767, 16'sd32767, 16'sd0}; rows.push_back(r);
		r.cmd = '{16'sd32767, 16'sd32767, 16'sd32767}; rows.push_back(r);
		r.cmd = '{-16'sd32768, -16'sd32768, -16'sd32768}; rows.push_back(r);
		r.cmd = '{16'sd0, 16'sd0, 16'sd256}; rows.push_back(r);
		r.cmd = '{16'sd0, 16'sd0, -16'sd256}; rows.push_back(r);
		r.cmd = '{16'sd1000, -16'sd500, 16'sd77}; rows.push_back(r);
		r.cmd = '{-16'sd1, 16'sd1, -16'sd1}; rows.push_back(r);
		r.cmd = '{-16'sd256, -16'sd1, 16'sd0}; rows.push_back(r);
		foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].has_exp, rows[i].exp);

		// register sweeps, extremes included, with random traffic per setting
		for (int s = 0; s < 4; s++) begin
			@(negedge clk);
			in_valid <= 1'b0;
			write_reg(REG_HALF_WHEELBASE, wb_set[s]);
			write_reg(REG_HALF_TRACK, tr_set[s]);
			// unused index leaves both registers alone
			write_reg(8'd2 + 8'($urandom_range(0, 253)), 16'($urandom));
			for (int n = 0; n < N_RANDOM / 4; n++) begin
				if (s == 1 && n == 20) hold_off = 1'b1;
				// back-to-back burst so the pipe fills behind the hold-off
				if (s == 1 && n >= 20 && n < 45) begin
					@(negedge clk);
					in_valid <= 1'b1;
					in_data  <= rand_cmd($urandom_range(0, 9));
					@(posedge clk);
					while (!in_ready) @(posedge clk);
					wheel_queue.push_back(wheel_targets(in_data));
					cmd_sent++;
				end else begin
					c = rand_cmd($urandom_range(0, 9));
					send_cmd(c, 1'b0, zero_w);
				end
				// sender pause until everything is drained
				if (s == 2 && n == 50) begin
					@(negedge clk);
					in_valid <= 1'b0;
					while (wheel_queue.size() != 0) @(posedge clk);
				end
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;
		write_reg(REG_HALF_WHEELBASE, HALF_WHEELBASE_RST);
		write_reg(REG_HALF_TRACK, HALF_TRACK_RST);
		for (int n = 0; n < 20; n++) send_cmd(rand_cmd($urandom_range(0, 9)), 1'b0, zero_w);
		@(negedge clk);
		in_valid <= 1'b0;

		while (wheel_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);

		$display("Covered %0d commands and %0d results over five register settings,",
			cmd_sent, res_seen);
		$display("with random stalls on both sides, a long output hold-off and a drain pause.");
		if (err_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", err_count);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
